// ===== rtl/rpn_stack_evaluator_macros.svh =====
// Assertion helpers shared by the evaluator modules.
`ifndef RPN_STACK_EVALUATOR_MACROS_SVH
`define RPN_STACK_EVALUATOR_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define RPN_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rpn evaluator check failed");

// Next-cycle implication, checked outside reset.
`define RPN_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rpn evaluator check failed");

`endif

// ===== rtl/rpn_pkg.sv =====
`timescale 1ns / 1ps

package rpn_pkg;

   // Character codes recognized by the evaluator.
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_STAR  = 8'h2A;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_SPACE = 8'h20;

   localparam int DATA_W      = 32;
   localparam int STATUS_W    = 3;
   localparam int QUEUE_DEPTH = 2;

   // Result status codes.
   typedef enum logic [STATUS_W-1:0] {
      ST_OK       = 3'd0,
      ST_BADCHAR  = 3'd1,
      ST_FEWOPS   = 3'd2,
      ST_DIVZERO  = 3'd3,
      ST_EMPTY    = 3'd4,
      ST_OVERFLOW = 3'd5
   } status_type;

   // Character classes produced by the front end.
   typedef enum logic [2:0] {
      K_DIGIT,
      K_ADD,
      K_SUB,
      K_MUL,
      K_DIV,
      K_SPACE,
      K_BAD
   } kind_type;

   // One classified character as it travels through the queue.
   typedef struct packed {
      kind_type   kind;
      logic [3:0] digit;
      logic       last;
   } cmd_type;

   // Divider request and response groups.
   typedef struct packed {
      logic              start;
      logic [DATA_W-1:0] dividend;
      logic [DATA_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [DATA_W-1:0] quotient;
   } div_rsp_type;

   // Back-end sequencer states.
   typedef enum logic [1:0] {
      BK_IDLE,
      BK_OPRD,
      BK_DIVW,
      BK_FIN
   } back_state_type;

endpackage

// ===== rtl/rpn_front.sv =====
`timescale 1ns / 1ps
`include "rpn_stack_evaluator_macros.svh"

module rpn_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [7:0]       req_tdata,   // [7:0] char_code
   input  logic             req_tlast,   // end_of_expr
   output logic             q_valid,
   output rpn_pkg::cmd_type q_item,
   input  logic             q_pop
);
   import rpn_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   cmd_type          slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   cmd_type          cmd_in;
   logic [7:0]       digit_offset;
   logic             push;

   // Classify the incoming character.
   always_comb begin
      digit_offset = req_tdata - CH_ZERO;
      cmd_in.digit = digit_offset[3:0];
      cmd_in.last  = req_tlast;
      if (req_tdata >= CH_ZERO && req_tdata <= CH_NINE) begin
         cmd_in.kind = K_DIGIT;
      end else if (req_tdata == CH_PLUS) begin
         cmd_in.kind = K_ADD;
      end else if (req_tdata == CH_MINUS) begin
         cmd_in.kind = K_SUB;
      end else if (req_tdata == CH_STAR) begin
         cmd_in.kind = K_MUL;
      end else if (req_tdata == CH_SLASH) begin
         cmd_in.kind = K_DIV;
      end else if (req_tdata == CH_SPACE) begin
         cmd_in.kind = K_SPACE;
      end else begin
         cmd_in.kind = K_BAD;
      end
   end

   // Queue handshake and pointer updates.
   assign req_tready = (cnt_ff != CNT_W'(QUEUE_DEPTH));
   assign push       = req_tvalid && req_tready;
   assign q_valid    = (cnt_ff != '0);
   assign q_item     = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push  ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = q_pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push && !q_pop) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end else if (q_pop && !push) begin
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Queue storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= cmd_in;
      end
   end

   `RPN_ASSERT_IMPL(a_no_pop_when_empty, clock, reset, q_pop, cnt_ff != '0)
   `RPN_ASSERT_NEXT(a_push_grows, clock, reset, push && !q_pop,
                    cnt_ff == $past(cnt_ff) + CNT_W'(1))
   `RPN_ASSERT_NEXT(a_pop_shrinks, clock, reset, q_pop && !push,
                    cnt_ff == $past(cnt_ff) - CNT_W'(1))

endmodule

// ===== rtl/rpn_div.sv =====
`timescale 1ns / 1ps

module rpn_div (
   input  logic                 clock,
   input  logic                 reset,
   input  rpn_pkg::div_req_type div_req,
   output rpn_pkg::div_rsp_type div_rsp
);
   import rpn_pkg::*;

   localparam int STEP_W = $clog2(DATA_W);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [DATA_W-1:0] rem_ff, rem_in;
   logic [DATA_W-1:0] quo_ff, quo_in;
   logic [DATA_W-1:0] den_ff, den_in;
   logic              neg_ff, neg_in;
   logic [DATA_W:0]   shifted;
   logic [DATA_W:0]   trial;

   // One restoring step per cycle on the operand magnitudes.
   always_comb begin
      shifted = {rem_ff, quo_ff[DATA_W-1]};
      trial   = shifted - {1'b0, den_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      neg_in  = neg_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         step_in = '0;
         rem_in  = '0;
         quo_in  = div_req.dividend[DATA_W-1] ? -div_req.dividend : div_req.dividend;
         den_in  = div_req.divisor[DATA_W-1] ? -div_req.divisor : div_req.divisor;
         neg_in  = div_req.dividend[DATA_W-1] ^ div_req.divisor[DATA_W-1];
      end else if (busy_ff) begin
         rem_in  = trial[DATA_W] ? shifted[DATA_W-1:0] : trial[DATA_W-1:0];
         quo_in  = {quo_ff[DATA_W-2:0], ~trial[DATA_W]};
         step_in = step_ff + STEP_W'(1);
         if (step_ff == STEP_W'(DATA_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      den_ff  <= den_in;
      neg_ff  <= neg_in;
   end

   // Restore the sign of the quotient.
   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = neg_ff ? -quo_ff : quo_ff;

endmodule

// ===== rtl/rpn_back.sv =====
`timescale 1ns / 1ps
`include "rpn_stack_evaluator_macros.svh"

module rpn_back #(
   parameter int STACK_DEPTH = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         q_valid,
   input  rpn_pkg::cmd_type             q_item,
   output logic                         q_pop,
   output rpn_pkg::div_req_type         div_req,
   input  rpn_pkg::div_rsp_type         div_rsp,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic signed [rpn_pkg::DATA_W-1:0]   rsp_tdata,  // [31:0] value
   output logic        [rpn_pkg::STATUS_W-1:0] rsp_tuser   // [2:0] status
);
   import rpn_pkg::*;

   localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
   localparam int ADDR_W = $clog2(STACK_DEPTH);

   // Entries below the top of stack; the top itself lives in tos_ff.
   logic [DATA_W-1:0] mem [STACK_DEPTH];

   back_state_type    state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   status_type        err_ff, err_in;
   logic [DATA_W-1:0] tos_ff, tos_in;
   logic [DATA_W-1:0] rd_data_ff;
   cmd_type           cmd_ff, cmd_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] rsp_value_ff, rsp_value_in;
   status_type        rsp_status_ff, rsp_status_in;

   logic              full, few, slot_free, is_op, tos_zero;
   logic              push_digit, rd_issue, arith_wr, div_start, div_wr, emit;
   logic              set_err;
   status_type        err_val;
   logic [CNT_W-1:0]  wr_idx, rd_idx;
   logic [DATA_W-1:0] alu_out;

   assign full      = (count_ff == CNT_W'(STACK_DEPTH));
   assign few       = (count_ff < CNT_W'(2));
   assign slot_free = !rsp_valid_ff || rsp_tready;
   assign is_op     = (q_item.kind == K_ADD) || (q_item.kind == K_SUB) ||
                      (q_item.kind == K_MUL) || (q_item.kind == K_DIV);
   assign tos_zero  = (tos_ff == '0);
   assign wr_idx    = count_ff - CNT_W'(1);
   assign rd_idx    = count_ff - CNT_W'(2);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: begin
            if (q_valid) begin
               if (err_ff == ST_OK && is_op && !few) begin
                  state_in = BK_OPRD;
               end else if (q_item.last) begin
                  state_in = BK_FIN;
               end
            end
         end
         BK_OPRD: begin
            if (cmd_ff.kind == K_DIV && !tos_zero) begin
               state_in = BK_DIVW;
            end else begin
               state_in = cmd_ff.last ? BK_FIN : BK_IDLE;
            end
         end
         BK_DIVW: begin
            if (div_rsp.done) begin
               state_in = cmd_ff.last ? BK_FIN : BK_IDLE;
            end
         end
         BK_FIN: begin
            if (slot_free) begin
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   // Control strobes for each state.
   always_comb begin
      q_pop      = 1'b0;
      push_digit = 1'b0;
      rd_issue   = 1'b0;
      arith_wr   = 1'b0;
      div_start  = 1'b0;
      div_wr     = 1'b0;
      emit       = 1'b0;
      set_err    = 1'b0;
      err_val    = ST_OK;
      case (state_ff)
         BK_IDLE: begin
            q_pop = q_valid;
            if (q_valid && err_ff == ST_OK) begin
               if (q_item.kind == K_DIGIT) begin
                  push_digit = !full;
                  set_err    = full;
                  err_val    = ST_OVERFLOW;
               end else if (q_item.kind == K_BAD) begin
                  set_err = 1'b1;
                  err_val = ST_BADCHAR;
               end else if (is_op) begin
                  rd_issue = !few;
                  set_err  = few;
                  err_val  = ST_FEWOPS;
               end
            end
         end
         BK_OPRD: begin
            if (cmd_ff.kind == K_DIV) begin
               div_start = !tos_zero;
               set_err   = tos_zero;
               err_val   = ST_DIVZERO;
            end else begin
               arith_wr = 1'b1;
            end
         end
         BK_DIVW: begin
            div_wr = div_rsp.done;
         end
         BK_FIN: begin
            emit = slot_free;
         end
         default: begin
            q_pop = 1'b0;
         end
      endcase
   end

   // Add, subtract and multiply on the second entry and the top of stack.
   always_comb begin
      case (cmd_ff.kind)
         K_SUB:   alu_out = rd_data_ff - tos_ff;
         K_MUL:   alu_out = rd_data_ff * tos_ff;
         default: alu_out = rd_data_ff + tos_ff;
      endcase
   end

   // Datapath next values.
   always_comb begin
      cmd_in        = q_pop ? q_item : cmd_ff;
      count_in      = count_ff;
      err_in        = set_err ? err_val : err_ff;
      tos_in        = tos_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      if (push_digit) begin
         count_in = count_ff + CNT_W'(1);
         tos_in   = {{(DATA_W - 4){1'b0}}, q_item.digit};
      end else if (arith_wr) begin
         count_in = count_ff - CNT_W'(1);
         tos_in   = alu_out;
      end else if (div_wr) begin
         count_in = count_ff - CNT_W'(1);
         tos_in   = div_rsp.quotient;
      end
      if (emit) begin
         rsp_valid_in = 1'b1;
         if (err_ff != ST_OK) begin
            rsp_value_in  = '0;
            rsp_status_in = err_ff;
         end else if (count_ff == '0) begin
            rsp_value_in  = '0;
            rsp_status_in = ST_EMPTY;
         end else begin
            rsp_value_in  = tos_ff;
            rsp_status_in = ST_OK;
         end
         count_in = '0;
         err_in   = ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         count_ff     <= '0;
         err_ff       <= ST_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         err_ff       <= err_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      tos_ff        <= tos_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

   // Stack memory: the old top spills on a push, the second entry is read for an operator.
   always_ff @(posedge clock) begin
      if (push_digit && count_ff != '0) begin
         mem[wr_idx[ADDR_W-1:0]] <= tos_ff;
      end
      if (rd_issue) begin
         rd_data_ff <= mem[rd_idx[ADDR_W-1:0]];
      end
   end

   assign div_req.start    = div_start;
   assign div_req.dividend = rd_data_ff;
   assign div_req.divisor  = tos_ff;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = $signed(rsp_value_ff);
   assign rsp_tuser  = rsp_status_ff;

   `RPN_ASSERT_IMPL(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(STACK_DEPTH))
   `RPN_ASSERT_IMPL(a_div_done_waits, clock, reset, div_rsp.done, state_ff == BK_DIVW)
   `RPN_ASSERT_NEXT(a_emit_clears, clock, reset, emit,
                    count_ff == '0 && err_ff == ST_OK && rsp_valid_ff)
   `RPN_ASSERT_IMPL(a_error_value_zero, clock, reset,
                    rsp_valid_ff && rsp_status_ff != ST_OK, rsp_value_ff == '0)

endmodule

// ===== rtl/rpn_stack_evaluator.sv =====
`timescale 1ns / 1ps
// Channel   Direction  Ports                          Contents
// req       in         req_tvalid/tready/tdata/tlast  tdata[7:0] char_code, tlast end_of_expr
// rsp       out        rsp_tvalid/tready/tdata/tuser  tdata[31:0] value, tuser[2:0] status
//
// A digit, space or bad character is handled in the idle state; + - * read the stack memory,
// then use the ALU, and / reads the stack memory, then waits for the one-bit-per-cycle divider.
// The character that ends an expression then passes through a state that loads the result register.
// Reset clears the stack count, the error and both handshakes; no clearing pass is run.
// A two-entry queue lets req accept up to two characters while the back end works, and rsp_tready
// low stalls the back end once the result register is full; req then stalls when the queue fills.

module rpn_stack_evaluator #(
   parameter int STACK_DEPTH = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic        [7:0]                    req_tdata,   // [7:0] char_code
   input  logic                                 req_tlast,   // end_of_expr
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic signed [rpn_pkg::DATA_W-1:0]    rsp_tdata,   // [31:0] value
   output logic        [rpn_pkg::STATUS_W-1:0]  rsp_tuser    // [2:0] status
);
   import rpn_pkg::*;

   logic        q_valid;
   logic        q_pop;
   cmd_type     q_item;
   div_req_type div_req;
   div_rsp_type div_rsp;

   rpn_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .q_pop      (q_pop)
   );

   rpn_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   rpn_back #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .q_pop      (q_pop),
      .div_req    (div_req),
      .div_rsp    (div_rsp),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
